FILE: rtl/sstq_pkg.sv
// Shared types, constants and the ordering function of the sorted timer queue.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package sstq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int FIRE_W = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0] FOREVER_LOOP = 8'd255;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_SERVICE = 2'd2,
    MODE_REMOVE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_PEND_MID,
    EMIT_PEND_LAST
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SORT,
    ST_REM_DEL,
    ST_SV_STEP,
    ST_SV_REINS,
    ST_SV_END,
    ST_RESP_OK,
    ST_RESP_FULL,
    ST_RESP_NF
  } fsm_state_t;

  typedef struct packed {
    logic [7:0]  id;
    logic        inner;
    logic        en;
    logic [15:0] ticks;
    logic [7:0]  loops;
    logic [15:0] reload;
    logic [7:0]  urg;
  } slot_t;

  typedef struct packed {
    logic    capture;
    logic    ins_new;
    logic    ins_reload;
    logic    dec;
    logic    sort_pass;
    logic    rem_match;
    logic    rem_del;
    logic    sv_start;
    logic    sv_skip;
    logic    sv_take;
    emit_t   emit;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  found;
    logic  sort_last;
    logic  sv_end;
    logic  sel_active;
    logic  sel_zero;
    logic  fires_max;
    logic  reload_nz;
    logic  has_pend;
    logic  out_free;
  } dp_sts_t;

  // a sorts ahead of b: fewer ticks, or equal ticks and higher urgency
  function automatic logic goes_before(slot_t a, slot_t b);
    logic r;
    if (a.ticks != b.ticks) begin
      r = (a.ticks < b.ticks);
    end else begin
      r = (a.urg > b.urg);
    end
    return r;
  endfunction

endpackage

FILE: rtl/sorted_software_timer_queue.sv
// Top level of the sorted timer queue: stream ports, sequencer and datapath.
// Depends on sstq_pkg, sstq_ctrl and sstq_datapath.
//
//   channel | dir | payload                              | transaction
//   s_*     | in  | tuser=mode, tdata=entry fields        | one request
//   m_*     | out | tuser=fired, tdata=id+status, tlast   | one result
//
// Insert and remove decode, then answer; tick decrements, then sorts
// (one odd-even sorting pass over the cells per cycle); service walks
// the entries, taking each fired one and reinserting it if it reloads.
// Requests are taken one at a time; s_tready is high only while idle.
// The result register lets the walk go on while a result waits on m_tready.
// Reset (rst, synchronous) empties the queue at once; no clearing pass.
`timescale 1ns / 1ps

module sorted_software_timer_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // timer_id[7:0], inner_class[8], enable_flag[9],
                                // start_ticks[25:10], repeat_count[33:26],
                                // reload_ticks[49:34], urgency[57:50], zero fill
  input  logic [1:0]  s_tuser,  // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // fired_id[7:0], status[9:8], zero fill
  output logic        m_tuser,  // fired
  output logic        m_tlast   // last_result
);

  sstq_pkg::dp_cmd_t cmd;
  sstq_pkg::dp_sts_t sts;
  logic in_accept;
  logic [7:0] fired_id;
  logic [1:0] status;

  assign in_accept = s_tvalid && s_tready;
  assign m_tdata = {6'd0, status, fired_id};

  sstq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_ready  (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sstq_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_mode    (s_tuser),
    .in_id      (s_tdata[7:0]),
    .in_inner   (s_tdata[8]),
    .in_en      (s_tdata[9]),
    .in_ticks   (s_tdata[25:10]),
    .in_loops   (s_tdata[33:26]),
    .in_reload  (s_tdata[49:34]),
    .in_urg     (s_tdata[57:50]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_fired  (m_tuser),
    .out_id     (fired_id),
    .out_status (status),
    .out_last   (m_tlast)
  );

endmodule

FILE: rtl/sstq_datapath.sv
// Entry cells, walk counters and result register of the sorted timer queue.
// Depends on sstq_pkg; driven by sstq_ctrl commands.
`timescale 1ns / 1ps

module sstq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_id,
  input  logic                in_inner,
  input  logic                in_en,
  input  logic [15:0]         in_ticks,
  input  logic [7:0]          in_loops,
  input  logic [15:0]         in_reload,
  input  logic [7:0]          in_urg,
  input  sstq_pkg::dp_cmd_t   cmd,
  output sstq_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_fired,
  output logic [7:0]          out_id,
  output logic [1:0]          out_status,
  output logic                out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  sstq_pkg::slot_t slots [DEPTH];
  sstq_pkg::slot_t req;
  sstq_pkg::slot_t taken;
  sstq_pkg::slot_t reloaded;
  sstq_pkg::slot_t ins_e;
  sstq_pkg::slot_t cur;
  sstq_pkg::mode_t mode;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [CW-1:0] steps;
  logic [IW-1:0] pass;
  logic [sstq_pkg::FIRE_W-1:0] fires;
  logic [7:0] pend_id;
  logic has_pend;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] any_above;
  logic [DEPTH-1:0] swap;
  logic out_free;

  assign ins_e = cmd.ins_reload ? taken : req;
  assign cur = slots[pos[IW-1:0]];
  assign out_free = !out_valid || out_ready;

  // entry as it goes back in after firing
  always_comb begin
    reloaded = cur;
    reloaded.ticks = cur.reload;
    if (cur.loops != sstq_pkg::FOREVER_LOOP) begin
      reloaded.loops = cur.loops - 8'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CW'(i) < count) && !sstq_pkg::goes_before(ins_e, slots[i]);
      any_above[i] = |(match & ({DEPTH{1'b1}} << (i + 1)));
      swap[i] = 1'b0;
      if (i < DEPTH - 1) begin
        swap[i] = (1'(i) == pass[0]) && (CW'(i + 1) < count) &&
                  sstq_pkg::goes_before(slots[i + 1], slots[i]);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.ins_new || cmd.ins_reload) begin
        if (!keep[g]) begin
          if (g == 0) begin
            slots[g] <= ins_e;
          end else if (keep[(g == 0) ? 0 : g - 1]) begin
            slots[g] <= ins_e;
          end else begin
            slots[g] <= slots[(g == 0) ? 0 : g - 1];
          end
        end
      end else if (cmd.dec) begin
        if (slots[g].en && slots[g].ticks != 16'd0) begin
          slots[g].ticks <= slots[g].ticks - 16'd1;
        end
      end else if (cmd.sort_pass) begin
        if (swap[g]) begin
          slots[g] <= slots[(g == DEPTH - 1) ? g : g + 1];
        end else if (g > 0 && swap[(g == 0) ? 0 : g - 1]) begin
          slots[g] <= slots[(g == 0) ? 0 : g - 1];
        end
      end else if (cmd.rem_del) begin
        if (!any_above[g] && g < DEPTH - 1) begin
          slots[g] <= slots[(g == DEPTH - 1) ? g : g + 1];
        end
      end else if (cmd.sv_take) begin
        if (CW'(g) >= pos && g < DEPTH - 1) begin
          slots[g] <= slots[(g == DEPTH - 1) ? g : g + 1];
        end
      end
    end
  end

  // request capture, remove match flags and the taken entry with its id
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode <= sstq_pkg::mode_t'(in_mode);
      req <= '{id: in_id, inner: in_inner, en: in_en, ticks: in_ticks,
               loops: in_loops, reload: in_reload, urg: in_urg};
    end
    if (cmd.rem_match) begin
      for (int i = 0; i < DEPTH; i++) begin
        match[i] <= (CW'(i) < count) && (slots[i].id == req.id);
      end
    end
    if (cmd.sv_take) begin
      taken <= reloaded;
      pend_id <= cur.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos <= '0;
      steps <= '0;
      pass <= '0;
      fires <= '0;
      has_pend <= 1'b0;
    end else begin
      if (cmd.ins_new || cmd.ins_reload) begin
        count <= count + CW'(1);
      end else if ((cmd.rem_del && |match) || cmd.sv_take) begin
        count <= count - CW'(1);
      end
      if (cmd.dec) begin
        pass <= '0;
      end else if (cmd.sort_pass) begin
        pass <= pass + IW'(1);
      end
      if (cmd.sv_start) begin
        pos <= '0;
        steps <= count;
        fires <= '0;
        has_pend <= 1'b0;
      end else if (cmd.sv_skip) begin
        pos <= pos + CW'(1);
        steps <= steps - CW'(1);
      end else if (cmd.sv_take) begin
        steps <= steps - CW'(1);
        fires <= fires + sstq_pkg::FIRE_W'(1);
        has_pend <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != sstq_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      sstq_pkg::EMIT_STATUS: begin
        out_fired <= 1'b0;
        out_id <= 8'd0;
        out_status <= cmd.status;
        out_last <= 1'b1;
      end
      sstq_pkg::EMIT_PEND_MID, sstq_pkg::EMIT_PEND_LAST: begin
        out_fired <= 1'b1;
        out_id <= pend_id;
        out_status <= sstq_pkg::STAT_OK;
        out_last <= (cmd.emit == sstq_pkg::EMIT_PEND_LAST);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.mode = mode;
    sts.full = (count == CW'(DEPTH));
    sts.found = |match;
    sts.sort_last = (pass == IW'(DEPTH - 1));
    sts.sv_end = (steps == '0) || (pos >= count);
    sts.sel_active = cur.en && (cur.inner == req.inner);
    sts.sel_zero = (cur.ticks == 16'd0);
    sts.fires_max = (fires >= sstq_pkg::FIRE_W'(sstq_pkg::MAX_RESULTS));
    sts.reload_nz = (cur.loops != 8'd0);
    sts.has_pend = has_pend;
    sts.out_free = out_free;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("entry count beyond depth");
  a_take_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.sv_take |=> count == $past(count) - CW'(1)) else $error("take lost count");
  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_new || cmd.ins_reload) |=> count == $past(count) + CW'(1))
    else $error("insert lost count");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != sstq_pkg::EMIT_NONE) |-> out_free) else $error("result overwritten");
`endif

endmodule

FILE: rtl/sstq_ctrl.sv
// Sequencer of the sorted timer queue: decodes each request and steps the datapath.
// Depends on sstq_pkg.
`timescale 1ns / 1ps

module sstq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  output logic              in_ready,
  input  sstq_pkg::dp_sts_t sts,
  output sstq_pkg::dp_cmd_t cmd
);

  sstq_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sstq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sstq_pkg::ST_IDLE: begin
        if (in_accept) state_next = sstq_pkg::ST_DECODE;
      end
      sstq_pkg::ST_DECODE: begin
        case (sts.mode)
          sstq_pkg::MODE_INSERT:
            state_next = sts.full ? sstq_pkg::ST_RESP_FULL : sstq_pkg::ST_RESP_OK;
          sstq_pkg::MODE_TICK: state_next = sstq_pkg::ST_SORT;
          sstq_pkg::MODE_REMOVE: state_next = sstq_pkg::ST_REM_DEL;
          default: state_next = sstq_pkg::ST_SV_STEP;
        endcase
      end
      sstq_pkg::ST_SORT: begin
        if (sts.sort_last) state_next = sstq_pkg::ST_RESP_OK;
      end
      sstq_pkg::ST_REM_DEL: begin
        state_next = sts.found ? sstq_pkg::ST_RESP_OK : sstq_pkg::ST_RESP_NF;
      end
      sstq_pkg::ST_SV_STEP: begin
        if (sts.sv_end || (sts.sel_active && (!sts.sel_zero || sts.fires_max))) begin
          state_next = sstq_pkg::ST_SV_END;
        end else if (sts.sel_active && (sts.out_free || !sts.has_pend) && sts.reload_nz) begin
          state_next = sstq_pkg::ST_SV_REINS;
        end
      end
      sstq_pkg::ST_SV_REINS: state_next = sstq_pkg::ST_SV_STEP;
      sstq_pkg::ST_SV_END, sstq_pkg::ST_RESP_OK, sstq_pkg::ST_RESP_FULL,
      sstq_pkg::ST_RESP_NF: begin
        if (sts.out_free) state_next = sstq_pkg::ST_IDLE;
      end
      default: state_next = sstq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit = sstq_pkg::EMIT_NONE;
    cmd.status = sstq_pkg::STAT_OK;
    in_ready = 1'b0;
    case (state)
      sstq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_accept;
      end
      sstq_pkg::ST_DECODE: begin
        case (sts.mode)
          sstq_pkg::MODE_INSERT: cmd.ins_new = !sts.full;
          sstq_pkg::MODE_TICK: cmd.dec = 1'b1;
          sstq_pkg::MODE_REMOVE: cmd.rem_match = 1'b1;
          default: cmd.sv_start = 1'b1;
        endcase
      end
      sstq_pkg::ST_SORT: cmd.sort_pass = 1'b1;
      sstq_pkg::ST_REM_DEL: cmd.rem_del = sts.found;
      sstq_pkg::ST_SV_STEP: begin
        if (!sts.sv_end) begin
          if (!sts.sel_active) begin
            cmd.sv_skip = 1'b1;
          end else if (sts.sel_zero && !sts.fires_max) begin
            if (!sts.has_pend) begin
              cmd.sv_take = 1'b1;
            end else if (sts.out_free) begin
              cmd.sv_take = 1'b1;
              cmd.emit = sstq_pkg::EMIT_PEND_MID;
            end
          end
        end
      end
      sstq_pkg::ST_SV_REINS: cmd.ins_reload = 1'b1;
      sstq_pkg::ST_SV_END: begin
        if (sts.out_free) begin
          cmd.emit = sts.has_pend ? sstq_pkg::EMIT_PEND_LAST : sstq_pkg::EMIT_STATUS;
        end
      end
      sstq_pkg::ST_RESP_OK: begin
        if (sts.out_free) cmd.emit = sstq_pkg::EMIT_STATUS;
      end
      sstq_pkg::ST_RESP_FULL: begin
        cmd.status = sstq_pkg::STAT_FULL;
        if (sts.out_free) cmd.emit = sstq_pkg::EMIT_STATUS;
      end
      sstq_pkg::ST_RESP_NF: begin
        cmd.status = sstq_pkg::STAT_NOT_FOUND;
        if (sts.out_free) cmd.emit = sstq_pkg::EMIT_STATUS;
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == sstq_pkg::ST_DECODE) else $error("accept not decoded");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.ins_new, cmd.ins_reload, cmd.dec, cmd.sort_pass, cmd.rem_del,
                cmd.sv_skip, cmd.sv_take}) <= 1) else $error("cell ops collide");
  a_reins_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_reload |-> $past(cmd.sv_take)) else $error("reinsert without take");
`endif

endmodule

FILE: verif/sorted_software_timer_queue_test.sv
// Self-checking bench for the sorted timer queue: directed and random requests.
// Depends on sstq_pkg and the sorted_software_timer_queue RTL.
`timescale 1ns / 1ps

class timer_queue_scoreboard;
  typedef struct {
    logic       fired;
    logic [7:0] id;
    logic [1:0] status;
    logic       last;
  } result_t;

  sstq_pkg::slot_t slots[$];
  result_t         pending[$];
  int              errors;

  function automatic bit ahead(sstq_pkg::slot_t a, sstq_pkg::slot_t b);
    if (a.ticks != b.ticks) return a.ticks < b.ticks;
    return a.urg > b.urg;
  endfunction

  function void sink(int p);
    sstq_pkg::slot_t t;
    while (p > 0 && ahead(slots[p], slots[p-1])) begin
      t = slots[p-1]; slots[p-1] = slots[p]; slots[p] = t; p--;
    end
  endfunction

  function void push_res(logic f, logic [7:0] id, logic [1:0] st, logic l);
    result_t r;
    r.fired = f; r.id = id; r.status = st; r.last = l;
    pending.push_back(r);
  endfunction

  // one accepted request: update the queue copy and queue its results
  function void note_request(logic [1:0] mode, logic [63:0] d);
    sstq_pkg::slot_t e;
    int steps, pos, fires, hit;
    case (mode)
      sstq_pkg::MODE_INSERT: begin
        if (slots.size() >= 16) begin
          push_res(0, 0, sstq_pkg::STAT_FULL, 1);
        end else begin
          e.id = d[7:0]; e.inner = d[8]; e.en = d[9]; e.ticks = d[25:10];
          e.loops = d[33:26]; e.reload = d[49:34]; e.urg = d[57:50];
          slots.push_back(e); sink(slots.size() - 1);
          push_res(0, 0, sstq_pkg::STAT_OK, 1);
        end
      end
      sstq_pkg::MODE_TICK: begin
        foreach (slots[i]) if (slots[i].en && slots[i].ticks != 0) slots[i].ticks--;
        for (int i = 1; i < slots.size(); i++) sink(i);
        push_res(0, 0, sstq_pkg::STAT_OK, 1);
      end
      sstq_pkg::MODE_REMOVE: begin
        hit = -1;
        foreach (slots[i]) if (slots[i].id == d[7:0]) hit = i;
        if (hit < 0) begin
          push_res(0, 0, sstq_pkg::STAT_NOT_FOUND, 1);
        end else begin
          slots.delete(hit);
          push_res(0, 0, sstq_pkg::STAT_OK, 1);
        end
      end
      default: begin
        steps = slots.size(); pos = 0; fires = 0;
        for (int i = 0; i < steps; i++) begin
          if (pos >= slots.size()) break;
          if (!slots[pos].en || slots[pos].inner != d[8]) begin
            pos++; continue;
          end
          if (slots[pos].ticks != 0 || fires >= sstq_pkg::MAX_RESULTS) break;
          e = slots[pos]; slots.delete(pos);
          push_res(1, e.id, sstq_pkg::STAT_OK, 0);
          fires++;
          if (e.loops != 0) begin
            if (e.loops != sstq_pkg::FOREVER_LOOP) e.loops--;
            e.ticks = e.reload;
            slots.push_back(e); sink(slots.size() - 1);
          end
        end
        if (fires == 0) push_res(0, 0, sstq_pkg::STAT_OK, 1);
        else pending[pending.size()-1].last = 1;
      end
    endcase
  endfunction

  function void check_result(logic f, logic [15:0] d, logic l);
    result_t r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result fired=%0b data=%h last=%0b", f, d, l);
      return;
    end
    r = pending.pop_front();
    if (f !== r.fired || d[7:0] !== r.id || d[9:8] !== r.status || d[15:10] !== 0
        || l !== r.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp fired=%0b id=%0d st=%0d last=%0b, got %0b %0d %0d %0b",
                 r.fired, r.id, r.status, r.last, f, d[7:0], d[9:8], l);
    end
  endfunction
endclass

module sorted_software_timer_queue_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  timer_queue_scoreboard board = new();
  int  cycle_count = 0;
  bit  quiet;       // no idling in the closing stretch
  int  stall_left = 0;
  logic [7:0] id_pool [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd77, 8'd128, 8'd200, 8'd255};

  always #4 clk = ~clk;

  sorted_software_timer_queue #(.DEPTH(16)) dut (.*);

  // accepted transactions are scored at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && s_tvalid && s_tready) board.note_request(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata, m_tlast);
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (quiet || rst) begin
      m_tready <= !rst;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  task automatic send(logic [1:0] mode, logic [7:0] id, logic cls, logic en,
                      logic [15:0] st, logic [7:0] rep, logic [15:0] rl, logic [7:0] urg);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= {6'b0, urg, rl, rep, st, en, cls, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(bit wellformed);
    logic [1:0] m;
    int r;
    r = $urandom_range(0, 99);
    if (!wellformed) m = 2'($urandom_range(0, 3));
    else if (r < 35) m = sstq_pkg::MODE_INSERT;
    else if (r < 65) m = sstq_pkg::MODE_TICK;
    else if (r < 88) m = sstq_pkg::MODE_SERVICE;
    else m = sstq_pkg::MODE_REMOVE;
    send(m, wellformed ? id_pool[$urandom_range(0, 7)] : 8'($urandom),
         1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
         wellformed ? 16'($urandom_range(0, 5)) : 16'($urandom),
         $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
         wellformed ? 16'($urandom_range(0, 4)) : 16'($urandom),
         8'($urandom));
  endtask

  initial begin
    quiet = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, every mode, full queue, duplicates, zero reload
    send(sstq_pkg::MODE_SERVICE, 8'd0, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    send(sstq_pkg::MODE_REMOVE, 8'd9, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    send(sstq_pkg::MODE_INSERT, 8'd255, 1'b1, 1'b1, 16'hffff, 8'd255, 16'hffff, 8'd255);
    send(sstq_pkg::MODE_INSERT, 8'd5, 1'b0, 1'b1, 16'd0, 8'd255, 16'd0, 8'd10);
    send(sstq_pkg::MODE_INSERT, 8'd6, 1'b0, 1'b1, 16'd0, 8'd2, 16'd0, 8'd200);
    send(sstq_pkg::MODE_SERVICE, 8'd0, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    send(sstq_pkg::MODE_REMOVE, 8'd5, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    for (int i = 0; i < 16; i++)
      send(sstq_pkg::MODE_INSERT, 8'(i % 4), 1'(i & 1), 1'(i != 3), 16'(i % 3),
           8'(i % 2), 16'(i % 2), 8'(i * 16));
    send(sstq_pkg::MODE_TICK, 8'd0, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    send(sstq_pkg::MODE_REMOVE, 8'd2, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    send(sstq_pkg::MODE_SERVICE, 8'd0, 1'b1, 1'b0, 16'd0, 8'd0, 16'd0, 8'd0);
    @(negedge clk);
    s_tvalid <= 0;

    // sender holds off until the queue of results drains
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);

    for (int i = 0; i < 170; i++) send_random($urandom_range(0, 9) != 0);
    quiet = 1;
    for (int i = 0; i < 40; i++) send_random(1'b1);
    @(negedge clk);
    s_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
